// ===== rtl/core/avimd_pkg.sv =====
package avimd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_IDX_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MOVI_BYTES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_BYTES = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_MAX  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_MAX  = CFG_IDX_W'(3);

  localparam logic [31:0] VIDEO_MAX_RST = 32'(200 * 1024);
  localparam logic [31:0] AUDIO_MAX_RST = 32'(64 * 1024);

  localparam logic [1:0] KIND_VIDEO = 2'd0;
  localparam logic [1:0] KIND_AUDIO = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  localparam logic [1:0] STOP_END_MOVI = 2'd0;
  localparam logic [1:0] STOP_INDEX    = 2'd1;
  localparam logic [1:0] STOP_BAD_SIZE = 2'd2;

  // fourcc codes, first byte in bits 7:0
  localparam logic [31:0] FCC_LIST = 32'h5453_494C;
  localparam logic [31:0] FCC_JUNK = 32'h4B4E_554A;
  localparam logic [31:0] FCC_IDIT = 32'h5449_4449;
  localparam logic [31:0] FCC_IDX1 = 32'h3178_6469;
  localparam logic [31:0] FCC_00DC = 32'h6364_3030;
  localparam logic [31:0] FCC_01DC = 32'h6364_3130;
  localparam logic [31:0] FCC_00WB = 32'h6277_3030;
  localparam logic [31:0] FCC_01WB = 32'h6277_3130;
  localparam logic [31:0] FCC_NONE = 32'h0000_0000;

  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_LTYPE = 3'd1,
    PH_PAYF  = 3'd2,
    PH_PAY   = 3'd3,
    PH_SKIP  = 3'd4
  } phase_t;

  // one parsed input beat: an optional payload result, then an optional stop
  typedef struct packed {
    logic       has_pay;
    logic [1:0] pay_kind;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       has_stop;
    logic [1:0] stop_reason;
  } event_t;

endpackage

// ===== rtl/core/avimd_parser.sv =====
module avimd_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [avimd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           accept,
  input  logic [7:0]                     in_byte,
  output logic                           ev_valid,
  output avimd_pkg::event_t              ev
);
  import avimd_pkg::*;

  logic [31:0] movi_bytes, file_bytes, video_max, audio_max;

  logic [33:0] offset, offset_next;
  logic [55:0] hs, hs_next;
  logic [2:0]  hcount, hcount_next;
  phase_t      phase, phase_next;
  logic [31:0] remaining, remaining_next;
  logic [1:0]  chunk_kind, chunk_kind_next;
  logic        pad_pending, pad_pending_next;
  logic        stopped, stopped_next;

  logic [63:0] word;
  logic [31:0] fcc, size;
  logic [32:0] padded;
  logic [33:0] off1, movi_ext;
  logic        end_now, end_after, bad_size, is_vid, is_aud, take_chunk, skip_type;
  logic        enter;

  assign word     = {in_byte, hs};
  assign fcc      = word[31:0];
  assign size     = word[63:32];
  assign padded   = {1'b0, size} + 33'(size[0]);
  assign off1     = offset + 34'd1;
  assign movi_ext = {2'b00, movi_bytes};
  assign end_now   = (offset + 34'd8) > movi_ext;
  assign end_after = (offset + 34'd9) > movi_ext;
  assign bad_size  = (size > file_bytes) || ((off1 + {1'b0, padded}) > (movi_ext + 34'd2));
  assign is_vid    = (fcc == FCC_00DC) || (fcc == FCC_01DC);
  assign is_aud    = (fcc == FCC_00WB) || (fcc == FCC_01WB);
  assign take_chunk = (size != 32'd0) &&
                      ((is_vid && size <= video_max) || (is_aud && size <= audio_max));
  assign skip_type  = (fcc == FCC_JUNK) || (fcc == FCC_IDIT) || (fcc == FCC_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      movi_bytes <= 32'd0;
      file_bytes <= 32'd0;
      video_max  <= VIDEO_MAX_RST;
      audio_max  <= AUDIO_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOVI_BYTES: movi_bytes <= cfg_data;
        CFG_FILE_BYTES: file_bytes <= cfg_data;
        CFG_VIDEO_MAX:  video_max  <= cfg_data;
        CFG_AUDIO_MAX:  audio_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset      <= '0;
      hcount      <= '0;
      phase       <= PH_HDR;
      remaining   <= '0;
      chunk_kind  <= KIND_VIDEO;
      pad_pending <= 1'b0;
      stopped     <= 1'b0;
    end else begin
      offset      <= offset_next;
      hcount      <= hcount_next;
      phase       <= phase_next;
      remaining   <= remaining_next;
      chunk_kind  <= chunk_kind_next;
      pad_pending <= pad_pending_next;
      stopped     <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    hs <= hs_next;
  end

  always_comb begin
    offset_next      = offset;
    hs_next          = hs;
    hcount_next      = hcount;
    phase_next       = phase;
    remaining_next   = remaining;
    chunk_kind_next  = chunk_kind;
    pad_pending_next = pad_pending;
    stopped_next     = stopped;
    ev               = '0;
    enter            = 1'b0;

    if (accept && !stopped) begin
      if (phase == PH_HDR && hcount == 3'd0 && end_now) begin
        ev.has_stop    = 1'b1;
        ev.stop_reason = STOP_END_MOVI;
        stopped_next   = 1'b1;
      end else begin
        offset_next = off1;
        unique case (phase)
          PH_HDR: begin
            hs_next = {in_byte, hs[55:8]};
            if (hcount == 3'd7) begin
              hcount_next = 3'd0;
              if (bad_size) begin
                ev.has_stop    = 1'b1;
                ev.stop_reason = STOP_BAD_SIZE;
                stopped_next   = 1'b1;
              end else if (fcc == FCC_LIST) begin
                phase_next = PH_LTYPE;
              end else if (fcc == FCC_IDX1 && !skip_type) begin
                ev.has_stop    = 1'b1;
                ev.stop_reason = STOP_INDEX;
                stopped_next   = 1'b1;
              end else if (!skip_type && take_chunk) begin
                phase_next       = PH_PAYF;
                remaining_next   = size;
                chunk_kind_next  = is_vid ? KIND_VIDEO : KIND_AUDIO;
                pad_pending_next = size[0];
              end else if (padded == 33'd0) begin
                enter = 1'b1;
              end else begin
                phase_next     = PH_SKIP;
                remaining_next = padded[31:0];
              end
            end else begin
              hcount_next = hcount + 3'd1;
            end
          end
          PH_LTYPE: begin
            hcount_next = hcount + 3'd1;
            if (hcount == 3'd3) enter = 1'b1;
          end
          PH_PAYF, PH_PAY: begin
            remaining_next = remaining - 32'd1;
            ev.has_pay     = 1'b1;
            ev.pay_kind    = chunk_kind;
            ev.data        = in_byte;
            ev.first       = (phase == PH_PAYF);
            ev.last        = (remaining == 32'd1);
            phase_next     = PH_PAY;
            if (remaining == 32'd1) begin
              if (pad_pending) begin
                pad_pending_next = 1'b0;
                phase_next       = PH_SKIP;
                remaining_next   = 32'd1;
              end else begin
                enter = 1'b1;
              end
            end
          end
          PH_SKIP: begin
            if (remaining != 32'd0) remaining_next = remaining - 32'd1;
            if (remaining <= 32'd1) enter = 1'b1;
          end
          default: begin
            phase_next  = PH_HDR;
            hcount_next = 3'd0;
          end
        endcase

        if (enter) begin
          phase_next  = PH_HDR;
          hcount_next = 3'd0;
          if (end_after) begin
            ev.has_stop    = 1'b1;
            ev.stop_reason = STOP_END_MOVI;
            stopped_next   = 1'b1;
          end
        end
      end
    end
  end

  assign ev_valid = ev.has_pay || ev.has_stop;

endmodule

// ===== rtl/core/avimd_fifo.sv =====
module avimd_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (rd_en) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (wr_en && !rd_en) count <= count + CNT_W'(1);
      else if (rd_en && !wr_en) count <= count - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/avimd_emit.sv =====
module avimd_emit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  avimd_pkg::event_t       q_data,
  output logic                    q_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              kind,
  output logic [7:0]              data,
  output logic                    chunk_first,
  output logic                    chunk_last,
  output logic [1:0]              stop_reason
);
  import avimd_pkg::*;

  logic   have;
  logic   sub;
  event_t cur;
  logic   show_pay, take, split, load;

  assign show_pay = cur.has_pay && !sub;
  assign take     = pop && have;
  assign split    = take && show_pay && cur.has_stop;
  assign load     = !have || (take && !split);
  assign q_pop    = load && !q_empty;
  assign empty    = !have;

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      sub  <= 1'b0;
    end else if (split) begin
      sub <= 1'b1;
    end else if (load) begin
      have <= !q_empty;
      sub  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !split) cur <= q_data;
  end

  always_comb begin
    if (show_pay) begin
      kind        = cur.pay_kind;
      data        = cur.data;
      chunk_first = cur.first;
      chunk_last  = cur.last;
      stop_reason = STOP_END_MOVI;
    end else begin
      kind        = KIND_STOP;
      data        = 8'd0;
      chunk_first = 1'b0;
      chunk_last  = 1'b0;
      stop_reason = cur.stop_reason;
    end
  end

endmodule

// ===== rtl/core/avi_movi_chunk_demux.sv =====
// channel   direction  handshake                     payload
// input     in         push / full                   in_byte
// result    out        empty / pop                   kind data chunk_first chunk_last stop_reason
// config    in         cfg_valid / cfg_ready         cfg_index cfg_data
//
// One byte a cycle while full is low: the parser classifies each beat in the cycle it is taken.
// A result is registered in the result queue and then in the emit stage before it reaches the result ports.
// A beat that gives a payload byte and a stop needs two pops: the payload first, then the stop.
// full rises when the result queue is full; cfg_ready is always high.
// rst is synchronous; after a stop all input is taken and dropped until reset.
module avi_movi_chunk_demux #(
  parameter int unsigned QUEUE_DEPTH = avimd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      in_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      kind,
  output logic [7:0]                      data,
  output logic                            chunk_first,
  output logic                            chunk_last,
  output logic [1:0]                      stop_reason,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [avimd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);
  import avimd_pkg::*;

  logic   ev_valid;
  event_t ev;
  logic   q_empty, q_pop;
  logic [$bits(event_t)-1:0] q_rd;

  assign cfg_ready = 1'b1;

  avimd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (push && !full),
    .in_byte   (in_byte),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  avimd_fifo #(
    .WIDTH ($bits(event_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ev_valid),
    .wr_data (ev),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  avimd_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (event_t'(q_rd)),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .data        (data),
    .chunk_first (chunk_first),
    .chunk_last  (chunk_last),
    .stop_reason (stop_reason)
  );

endmodule
